// ----- src/oom_pkg.sv -----
// Shared types and constants of the occupancy and overload monitor.
`timescale 1ns / 1ps
package oom_pkg;

  localparam int LOAD_W      = 24;
  localparam int THR_W       = 25;
  localparam int TIMEOUT_W   = 16;
  localparam int COUNT_W     = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 25;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOAD_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REST_LEVEL     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PASS_TIMEOUT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_LIMIT    = 2'd3;

  localparam logic [TIMEOUT_W-1:0] PASS_TIMEOUT_RST = 16'd500;
  localparam logic [COUNT_W-1:0]   COUNT_LIMIT_RST  = 4'd5;
  localparam logic [COUNT_W-1:0]   PEOPLE_MAX       = 4'd9;

  typedef struct packed {
    logic                     beam_outer;
    logic                     beam_inner;
    logic                     call_edge;
    logic signed [LOAD_W-1:0] load_sample;
  } item_t;

  typedef struct packed {
    logic signed [THR_W-1:0] load_threshold;
    logic [TIMEOUT_W-1:0]    pass_timeout;
    logic [COUNT_W-1:0]      count_limit;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       occupancy;
    logic                     overload;
    logic                     door_cycle;
    logic signed [LOAD_W-1:0] filtered_load;
  } res_t;

endpackage

// ----- src/occupancy_overload_monitor_top.sv -----
// Top level of the lift occupancy and overload monitor.
`timescale 1ns / 1ps
// One input transaction is one sensor tick: two beam flags, call sensor, call
// button and a signed 24-bit load sample. Every tick yields exactly one output
// transaction: people count, overload flag, door-cycle request and the moving
// average of the last AVG_DEPTH load samples.
// An input transaction is taken every cycle while the two-entry input queue
// has room; results leave one per cycle while the receiver is ready. From
// input acceptance a result passes through the queue, the running-sum and beam
// state update, the reciprocal multiply and the output register.
// When the receiver stalls, the output register holds its transaction and the
// pipeline halts; the queue fills and then tready drops.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while no
// tick is in flight. Writing rest_level presets every averaging entry at once.
// Reset clears the count, the beam machine and the edge memory, fills the
// averaging store with zero and loads threshold 0, timeout 500, limit 5.
module occupancy_overload_monitor_top #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // beam_outer, beam_inner, call_sensor, call_button, load_sample[23:0], zero pad
  input  logic [oom_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // occupancy[3:0], overload, door_cycle, filtered_load[23:0], zero pad
  output logic [oom_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [oom_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [oom_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import oom_pkg::*;

  cfg_t  cfg_q, cfg_d;
  item_t push_item, head_item;
  res_t  res;
  logic  push, full, head_valid, pop, preset;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LOAD_THRESHOLD: cfg_d.load_threshold = cfg_wdata_i;
        CFG_PASS_TIMEOUT:   cfg_d.pass_timeout   = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_COUNT_LIMIT:    cfg_d.count_limit    = cfg_wdata_i[COUNT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  assign preset = cfg_we_i && (cfg_addr_i == CFG_REST_LEVEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_threshold <= '0;
      cfg_q.pass_timeout   <= PASS_TIMEOUT_RST;
      cfg_q.count_limit    <= COUNT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  oom_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  oom_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  oom_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .preset_i       (preset),
    .preset_level_i (cfg_wdata_i[LOAD_W-1:0]),
    .q_valid_i      (head_valid),
    .q_item_i       (head_item),
    .q_pop_o        (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .res_o          (res)
  );

  assign m_axis_tdata = {2'b00, res.filtered_load, res.door_cycle, res.overload,
                         res.occupancy};

endmodule

// ----- src/oom_front.sv -----
// Input side: take transactions, detect call edges, push items into the queue.
`timescale 1ns / 1ps
module oom_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // beam_outer, beam_inner, call_sensor, call_button, load_sample[23:0], zero pad
  input  logic [oom_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            full_i,
  output logic                            push_o,
  output oom_pkg::item_t                  item_o
);
  import oom_pkg::*;

  logic sensor_prev_q, sensor_prev_d;
  logic button_prev_q, button_prev_d;
  logic sensor, button, accept;

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  assign push_o          = accept;

  assign sensor = s_axis_tdata_i[2];
  assign button = s_axis_tdata_i[3];

  assign item_o.beam_outer  = s_axis_tdata_i[0];
  assign item_o.beam_inner  = s_axis_tdata_i[1];
  assign item_o.call_edge   = (sensor && !sensor_prev_q) || (button && !button_prev_q);
  assign item_o.load_sample = s_axis_tdata_i[4 +: LOAD_W];

  assign sensor_prev_d = accept ? sensor : sensor_prev_q;
  assign button_prev_d = accept ? button : button_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_prev_q <= 1'b0;
      button_prev_q <= 1'b0;
    end else begin
      sensor_prev_q <= sensor_prev_d;
      button_prev_q <= button_prev_d;
    end
  end

endmodule

// ----- src/oom_queue.sv -----
// Two-entry queue between the input side and the processing pipeline.
`timescale 1ns / 1ps
module oom_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  oom_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output oom_pkg::item_t item_o
);
  import oom_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- src/oom_back.sv -----
// Processing pipeline: moving average, beam machine, divide, overload and door decision.
`timescale 1ns / 1ps
module oom_back #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oom_pkg::cfg_t                       cfg_i,
  input  logic                                preset_i,
  input  logic signed [oom_pkg::LOAD_W-1:0]   preset_level_i,
  input  logic                                q_valid_i,
  input  oom_pkg::item_t                      q_item_i,
  output logic                                q_pop_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output oom_pkg::res_t                       res_o
);
  import oom_pkg::*;

  localparam int L      = $clog2(AVG_DEPTH);
  localparam int SUM_W  = LOAD_W + L;
  localparam int K      = LOAD_W - 1 + 2 * L;
  localparam int M_W    = LOAD_W + L;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [M_W-1:0] RECIP =
    M_W'(((64'd1 << K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_OUTER   = 4'b0010,
    PH_INNER   = 4'b0100,
    PH_RELEASE = 4'b1000
  } phase_e;

  logic signed [LOAD_W-1:0] ring_q [AVG_DEPTH];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  phase_e                   phase_q, phase_d;
  logic [TIMEOUT_W-1:0]     ticks_q, ticks_d, ticks_inc;
  logic [COUNT_W-1:0]       people_q, people_d;

  logic signed [SUM_W-1:0]  old_ext, new_ext, level_ext, step_sum;
  logic                     en, pop;

  logic                     s1_valid_q;
  logic signed [SUM_W-1:0]  s1_sum_q;
  logic                     s1_edge_q, s1_count_over_q;
  logic [COUNT_W-1:0]       s1_people_q;

  logic                     s2_valid_q;
  logic                     s2_neg_q, s2_edge_q, s2_count_over_q;
  logic [COUNT_W-1:0]       s2_people_q;
  logic [LOAD_W-1:0]        s2_quot_q;
  logic [SUM_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;

  logic                     out_valid_q;
  res_t                     out_q;
  logic signed [LOAD_W-1:0] avg;
  logic                     over;

  assign en      = !out_valid_q || m_ready_i;
  assign pop     = en && q_valid_i;
  assign q_pop_o = pop;

  assign old_ext   = {{L{ring_q[AVG_DEPTH-1][LOAD_W-1]}}, ring_q[AVG_DEPTH-1]};
  assign new_ext   = {{L{q_item_i.load_sample[LOAD_W-1]}}, q_item_i.load_sample};
  assign level_ext = {{L{preset_level_i[LOAD_W-1]}}, preset_level_i};
  assign step_sum  = sum_q - old_ext + new_ext;

  always_comb begin
    sum_d = sum_q;
    if (preset_i) begin
      sum_d = level_ext * $signed(SUM_W'(AVG_DEPTH));
    end else if (pop) begin
      sum_d = step_sum;
    end
  end

  assign ticks_inc = ticks_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    people_d = people_q;
    case (phase_q)
      PH_IDLE: begin
        if (q_item_i.beam_outer && !q_item_i.beam_inner) begin
          ticks_d = '0;
          phase_d = PH_OUTER;
        end else if (q_item_i.beam_inner && !q_item_i.beam_outer) begin
          ticks_d = '0;
          phase_d = PH_INNER;
        end
      end
      PH_OUTER: begin
        if (q_item_i.beam_inner) begin
          people_d = (people_q == PEOPLE_MAX) ? '0 : people_q + 4'd1;
          phase_d  = PH_RELEASE;
        end else begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.pass_timeout) begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_INNER: begin
        if (q_item_i.beam_outer) begin
          people_d = (people_q == '0) ? PEOPLE_MAX : people_q - 4'd1;
          phase_d  = PH_RELEASE;
        end else begin
          ticks_d = ticks_inc;
          if (ticks_inc >= cfg_i.pass_timeout) begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_RELEASE: begin
        if (!q_item_i.beam_outer && !q_item_i.beam_inner) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      sum_q    <= '0;
      phase_q  <= PH_IDLE;
      ticks_q  <= '0;
      people_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (preset_i) begin
        for (int i = 0; i < AVG_DEPTH; i++) begin
          ring_q[i] <= preset_level_i;
        end
      end else if (pop) begin
        ring_q[0] <= q_item_i.load_sample;
        for (int i = 1; i < AVG_DEPTH; i++) begin
          ring_q[i] <= ring_q[i-1];
        end
      end
      if (pop) begin
        phase_q  <= phase_d;
        ticks_q  <= ticks_d;
        people_q <= people_d;
      end
    end
  end

  assign mag  = s1_sum_q[SUM_W-1] ? SUM_W'(-s1_sum_q) : SUM_W'(s1_sum_q);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);

  assign avg  = s2_neg_q ? -$signed(s2_quot_q) : $signed(s2_quot_q);
  assign over = ($signed({avg[LOAD_W-1], avg}) > cfg_i.load_threshold) || s2_count_over_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q        <= step_sum;
      s1_edge_q       <= q_item_i.call_edge;
      s1_count_over_q <= people_q > cfg_i.count_limit;
      s1_people_q     <= people_d;
      s2_neg_q        <= s1_sum_q[SUM_W-1];
      s2_quot_q       <= prod[K +: LOAD_W];
      s2_edge_q       <= s1_edge_q;
      s2_count_over_q <= s1_count_over_q;
      s2_people_q     <= s1_people_q;
      out_q.occupancy     <= s2_people_q;
      out_q.overload      <= over;
      out_q.door_cycle    <= !over && s2_edge_q;
      out_q.filtered_load <= avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = out_q;

endmodule

// ----- src/oom_checker.sv -----
// Port-level assertions for the monitor, bound to the top level.
`timescale 1ns / 1ps
module oom_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [oom_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import oom_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= PEOPLE_MAX)
    else $error("occupancy out of range");

  a_door_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]))
    else $error("door cycle during overload");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready [*3] |=> m_axis_tvalid)
    else $error("no result four cycles after an accepted tick with the receiver ready");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

endmodule

bind occupancy_overload_monitor_top oom_checker u_oom_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench of the occupancy and overload monitor over its stream ports.
`timescale 1ns / 1ps
module tb_top;
  import oom_pkg::*;

  localparam int AVG_DEPTH      = 8;
  localparam int PHASE_TICKS    = 205;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LOAD_MIN       = -(1 << (LOAD_W - 1));
  localparam int LOAD_MAX       = (1 << (LOAD_W - 1)) - 1;

  typedef enum logic [1:0] {
    PASS_IDLE,
    PASS_OUTER_FIRST,
    PASS_INNER_FIRST,
    PASS_RELEASE
  } pass_phase_e;

  typedef enum int {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic                     beam_outer;
    logic                     beam_inner;
    logic                     call_sensor;
    logic                     call_button;
    logic signed [LOAD_W-1:0] load_sample;
  } tick_t;

  typedef struct packed {
    logic [COUNT_W-1:0]       occupancy;
    logic                     overload;
    logic                     door_cycle;
    logic signed [LOAD_W-1:0] filtered_load;
  } cabin_status_t;

  class cabin_status_model;
    logic signed [THR_W-1:0]  load_threshold;
    logic signed [LOAD_W-1:0] rest_level;
    logic [TIMEOUT_W-1:0]     pass_timeout;
    logic [COUNT_W-1:0]       count_limit;
    logic signed [LOAD_W-1:0] load_ring [AVG_DEPTH];
    int                       ring_idx;
    int                       ring_total;
    pass_phase_e              phase;
    logic [TIMEOUT_W-1:0]     wait_ticks;
    logic [COUNT_W-1:0]       people;
    logic                     sensor_prev;
    logic                     button_prev;
    cabin_status_t            status_q[$];
    int                       errors;

    function new();
      load_threshold = '0;
      rest_level     = '0;
      pass_timeout   = PASS_TIMEOUT_RST;
      count_limit    = COUNT_LIMIT_RST;
      preset_ring();
      phase       = PASS_IDLE;
      wait_ticks  = '0;
      people      = '0;
      sensor_prev = 1'b0;
      button_prev = 1'b0;
      errors      = 0;
    endfunction

    function void preset_ring();
      int rest_v;
      rest_v = int'(rest_level);
      for (int i = 0; i < AVG_DEPTH; i++) load_ring[i] = rest_level;
      ring_total = rest_v * AVG_DEPTH;
      ring_idx   = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOAD_THRESHOLD: load_threshold = val[THR_W-1:0];
        CFG_REST_LEVEL: begin
          rest_level = val[LOAD_W-1:0];
          preset_ring();
        end
        CFG_PASS_TIMEOUT: pass_timeout = val[TIMEOUT_W-1:0];
        CFG_COUNT_LIMIT:  count_limit  = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void take_tick(tick_t t);
      int            old_v;
      int            new_v;
      int            avg;
      int            thr_v;
      logic          over;
      logic          door;
      cabin_status_t s;
      old_v = int'(load_ring[ring_idx]);
      new_v = int'(t.load_sample);
      ring_total = ring_total - old_v + new_v;
      load_ring[ring_idx] = t.load_sample;
      ring_idx = (ring_idx + 1) % AVG_DEPTH;
      avg   = ring_total / AVG_DEPTH;
      thr_v = int'(load_threshold);
      over  = (avg > thr_v) || (people > count_limit);
      door  = !over && ((t.call_sensor && !sensor_prev) || (t.call_button && !button_prev));
      sensor_prev = t.call_sensor;
      button_prev = t.call_button;
      case (phase)
        PASS_IDLE: begin
          if (t.beam_outer && !t.beam_inner) begin
            wait_ticks = '0;
            phase      = PASS_OUTER_FIRST;
          end else if (t.beam_inner && !t.beam_outer) begin
            wait_ticks = '0;
            phase      = PASS_INNER_FIRST;
          end
        end
        PASS_OUTER_FIRST: begin
          if (t.beam_inner) begin
            people = (people < PEOPLE_MAX) ? people + 1'b1 : '0;
            phase  = PASS_RELEASE;
          end else begin
            wait_ticks = wait_ticks + 1'b1;
            if (wait_ticks >= pass_timeout) phase = PASS_IDLE;
          end
        end
        PASS_INNER_FIRST: begin
          if (t.beam_outer) begin
            people = (people != '0) ? people - 1'b1 : PEOPLE_MAX;
            phase  = PASS_RELEASE;
          end else begin
            wait_ticks = wait_ticks + 1'b1;
            if (wait_ticks >= pass_timeout) phase = PASS_IDLE;
          end
        end
        default: begin
          if (!t.beam_outer && !t.beam_inner) phase = PASS_IDLE;
        end
      endcase
      s.occupancy     = people;
      s.overload      = over;
      s.door_cycle    = door;
      s.filtered_load = avg[LOAD_W-1:0];
      status_q.push_back(s);
    endfunction

    function void report(string what, int want, int got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    endfunction

    function void check_status(logic [OUT_TDATA_W-1:0] d);
      cabin_status_t            s;
      logic signed [LOAD_W-1:0] got_load;
      if (status_q.size() == 0) begin
        $display("%0t: result with no tick pending, expected none actual %h", $time, d);
        errors++;
        return;
      end
      s = status_q.pop_front();
      got_load = d[6 +: LOAD_W];
      if (d[3:0] !== s.occupancy) report("occupancy", int'(s.occupancy), int'(d[3:0]));
      if (d[4] !== s.overload) report("overload", int'(s.overload), int'(d[4]));
      if (d[5] !== s.door_cycle) report("door_cycle", int'(s.door_cycle), int'(d[5]));
      if (got_load !== s.filtered_load)
        report("filtered_load", int'(s.filtered_load), int'(got_load));
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  cabin_status_model model = new();
  tick_t             tick_q[$];
  int                tx_idle_pct  = 0;
  int                rx_idle_pct  = 0;
  int                stall_cycles = 0;
  int                cur_timeout  = int'(PASS_TIMEOUT_RST);
  int                load_base    = 0;
  int                load_mix     = 20;
  bit                sensor_level = 1'b0;
  bit                button_level = 1'b0;

  occupancy_overload_monitor_top #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) model.check_status(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[occupancy_overload_monitor_top] ERROR");
        $finish;
      end
    end
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        tx_idle_pct = 32;
        rx_idle_pct = 53;
      end
      IDLE_SENDER_HEAVY: begin
        tx_idle_pct = 53;
        rx_idle_pct = 32;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endfunction

  function automatic logic signed [LOAD_W-1:0] pick_load();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 2) return LOAD_W'(LOAD_MIN);
    if (r < 4) return LOAD_W'(LOAD_MAX);
    if (r < 4 + load_mix) begin
      v = $urandom;
      return v[LOAD_W-1:0];
    end
    v = load_base + $urandom_range(0, 8192) - 4096;
    if (v < LOAD_MIN) v = LOAD_MIN;
    if (v > LOAD_MAX) v = LOAD_MAX;
    return v[LOAD_W-1:0];
  endfunction

  function automatic void push_directed(bit outer, bit inner, bit cs, bit cb, int load);
    tick_t t;
    t.beam_outer  = outer;
    t.beam_inner  = inner;
    t.call_sensor = cs;
    t.call_button = cb;
    t.load_sample = load[LOAD_W-1:0];
    tick_q.push_back(t);
  endfunction

  function automatic void push_beam(bit outer, bit inner);
    if ($urandom_range(0, 3) == 0) sensor_level = ~sensor_level;
    if ($urandom_range(0, 3) == 0) button_level = ~button_level;
    push_directed(outer, inner, sensor_level, button_level, pick_load());
  endfunction

  // a passage, whole or broken off, with waits up to the beam timeout plus two, at most 12 ticks
  function automatic void add_passage(bit entering);
    int wmax;
    wmax = (cur_timeout < 12) ? cur_timeout + 2 : 12;
    repeat ($urandom_range(1, wmax)) push_beam(entering, !entering);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, wmax)) push_beam(1'b0, 1'b0);
    if ($urandom_range(0, 4) != 0) begin
      repeat ($urandom_range(0, 3)) push_beam(1'b1, 1'b1);
      repeat ($urandom_range(1, 3)) push_beam(!entering, entering);
    end
    repeat ($urandom_range(1, 3)) push_beam(1'b0, 1'b0);
  endfunction

  function automatic void build_random(int n);
    int r;
    while (tick_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) add_passage(1'b1);
      else if (r < 85) add_passage(1'b0);
      else repeat ($urandom_range(1, 6))
        push_beam(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic send_tick(tick_t t);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[0] = t.beam_outer;
    d[1] = t.beam_inner;
    d[2] = t.call_sensor;
    d[3] = t.call_button;
    d[4 +: LOAD_W] = t.load_sample;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    model.take_tick(t);
  endtask

  task automatic stop_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results();
    while (model.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_ticks(bit pause_midway);
    for (int k = 0; k < tick_q.size(); k++) begin
      send_tick(tick_q[k]);
      if (pause_midway && k == tick_q.size() / 2) begin
        stop_stream();
        wait_results();
      end
    end
    stop_stream();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    tick_q.delete();
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    model.write_reg(idx, val);
  endtask

  task automatic set_limits(int thr, int rest, int tmo, int lim);
    write_reg(CFG_LOAD_THRESHOLD, thr[CFG_DATA_W-1:0]);
    write_reg(CFG_REST_LEVEL, {1'b0, rest[LOAD_W-1:0]});
    write_reg(CFG_PASS_TIMEOUT, {{(CFG_DATA_W-TIMEOUT_W){1'b0}}, tmo[TIMEOUT_W-1:0]});
    write_reg(CFG_COUNT_LIMIT, {{(CFG_DATA_W-COUNT_W){1'b0}}, lim[COUNT_W-1:0]});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_timeout = tmo;
  endtask

  initial begin
    int thr;
    int rest;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(IDLE_SENDER_LIGHT);
    push_directed(1'b0, 1'b0, 1'b1, 1'b0, 0);
    push_directed(1'b0, 1'b0, 1'b1, 1'b1, 0);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, 0);
    push_directed(1'b1, 1'b0, 1'b0, 1'b0, LOAD_MAX);
    push_directed(1'b1, 1'b1, 1'b0, 1'b0, LOAD_MAX);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, LOAD_MAX);
    push_directed(1'b0, 1'b1, 1'b0, 1'b0, LOAD_MIN);
    push_directed(1'b1, 1'b1, 1'b0, 1'b0, LOAD_MIN);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, LOAD_MIN);
    push_directed(1'b0, 1'b1, 1'b0, 1'b0, 0);
    push_directed(1'b1, 1'b0, 1'b0, 1'b0, 0);
    push_directed(1'b0, 1'b0, 1'b1, 1'b0, 0);
    push_directed(1'b0, 1'b0, 1'b1, 1'b0, 0);
    push_directed(1'b1, 1'b1, 1'b0, 1'b1, 0);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, 0);
    push_directed(1'b1, 1'b0, 1'b0, 1'b0, 0);
    push_directed(1'b0, 1'b1, 1'b0, 1'b0, 0);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, 0);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, -3);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, -9);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, 5);
    push_directed(1'b0, 1'b0, 1'b1, 1'b1, LOAD_MIN);
    push_directed(1'b0, 1'b0, 1'b0, 1'b0, LOAD_MAX);
    run_ticks(1'b0);

    for (int p = 1; p <= 9; p++) begin
      if (p < 3) set_idling(IDLE_SENDER_LIGHT);
      else if (p < 6) set_idling(IDLE_SENDER_HEAVY);
      else set_idling(IDLE_NONE);
      load_base = $urandom_range(0, 1 << 23) - (1 << 22);
      load_mix  = $urandom_range(2, 30);
      thr  = load_base + $urandom_range(0, 6000) - 3000;
      rest = $urandom_range(0, (1 << LOAD_W) - 1) - (1 << (LOAD_W - 1));
      case (p)
        1: set_limits(-(1 << (THR_W - 1)), LOAD_MIN, 0, 0);
        2: set_limits((1 << (THR_W - 1)) - 1, LOAD_MAX, (1 << TIMEOUT_W) - 1, 15);
        3: set_limits(thr, load_base, 1, int'(PEOPLE_MAX));
        default: set_limits(thr, rest, $urandom_range(0, 20), $urandom_range(0, 15));
      endcase
      build_random(PHASE_TICKS);
      run_ticks(p == 2 || p == 7);
    end

    if (model.errors == 0 && model.pending() == 0) begin
      $display("[occupancy_overload_monitor_top] OK");
    end else begin
      $display("[occupancy_overload_monitor_top] ERROR");
    end
    $finish;
  end

endmodule
